### design/histogram_stats_engine_core_assert.svh
// Assertion macros shared by the histogram statistics engine modules
`ifndef HISTOGRAM_STATS_ENGINE_CORE_ASSERT_SVH
`define HISTOGRAM_STATS_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define HSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define HSE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define HSE_ASSERT(lbl, prop, msg)
`define HSE_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### design/hse_pkg.sv
// Types, constants and command bundles of the histogram statistics engine
`default_nettype none

package hse_pkg;

  localparam int unsigned NUM_BINS    = 100;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned BIN_W       = $clog2(NUM_BINS);
  localparam int unsigned TOTAL_W     = COUNT_WIDTH + BIN_W;
  localparam int unsigned WSUM_W      = COUNT_WIDTH + 2 * BIN_W;
  localparam int unsigned DIVC_W      = $clog2(BIN_W + 1);
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned BIN_OUT_W   = 7;
  localparam int unsigned TOTAL_OUT_W = 23;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RECORD = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_REPORT = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_WR,
    ST_SUM,
    ST_MED,
    ST_DIV,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic rec_rd;
    logic rec_wr;
    logic clr;
    logic walk_init;
    logic walk_run;
    logic init_sum;
    logic acc_sum;
    logic init_med;
    logic acc_med;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic walk_last;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### design/hse_req_if.sv
// Request channel: action and sample with valid/ready
`default_nettype none

interface hse_req_if;
  logic                           valid;
  logic                           ready;
  logic [hse_pkg::ACTION_W-1:0]   action;
  logic [hse_pkg::SAMPLE_W-1:0]   sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

`default_nettype wire

### design/hse_rsp_if.sv
// Result channel: histogram statistics with valid/ready
`default_nettype none

interface hse_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [hse_pkg::BIN_OUT_W-1:0]    mean_bin;
  logic [hse_pkg::BIN_OUT_W-1:0]    mode_bin;
  logic [hse_pkg::BIN_OUT_W-1:0]    median_bin;
  logic [hse_pkg::TOTAL_OUT_W-1:0]  total_count;
  logic                             empty_res;

  modport source (output valid, output mean_bin, output mode_bin, output median_bin,
                  output total_count, output empty_res, input ready);
  modport sink   (input valid, input mean_bin, input mode_bin, input median_bin,
                  input total_count, input empty_res, output ready);
endinterface

`default_nettype wire

### design/hse_ram.sv
// Generic single-port-write, registered-read RAM
`default_nettype none

module hse_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 100
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/hse_dp.sv
// Datapath: bin store, walk pipeline, accumulators, divider and result register
`default_nettype none

`include "histogram_stats_engine_core_assert.svh"

module hse_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [hse_pkg::SAMPLE_W-1:0]        sample_i,
  input  wire hse_pkg::cmd_t                       cmd_i,
  output hse_pkg::sts_t                            sts_o,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic      [hse_pkg::BIN_OUT_W-1:0]       mean_bin_o,
  output logic      [hse_pkg::BIN_OUT_W-1:0]       mode_bin_o,
  output logic      [hse_pkg::BIN_OUT_W-1:0]       median_bin_o,
  output logic      [hse_pkg::TOTAL_OUT_W-1:0]     total_count_o,
  output logic                                     empty_res_o
);

  localparam int unsigned BW  = hse_pkg::BIN_W;
  localparam int unsigned CW  = hse_pkg::COUNT_WIDTH;
  localparam int unsigned TW  = hse_pkg::TOTAL_W;
  localparam int unsigned WW  = hse_pkg::WSUM_W;
  localparam int unsigned DCW = hse_pkg::DIVC_W;
  localparam int unsigned NB  = hse_pkg::NUM_BINS;

  // bin store and valid bits
  logic [NB-1:0] valid_q, valid_d;
  logic          vld_rd_q;
  logic [BW-1:0] sample_q;
  logic          ram_re;
  logic [BW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;
  logic [CW-1:0] cnt;
  logic [CW-1:0] wdata;

  // walk pipeline
  logic [BW-1:0] walk_addr_q, walk_addr_d;
  logic          issuing_q, issuing_d;
  logic          pend_q, pend_d;
  logic [BW-1:0] rd_idx_q, rd_idx_d;

  // accumulators
  logic [TW-1:0] total_q, total_d;
  logic [WW-1:0] wsum_q, wsum_d;
  logic [CW-1:0] best_q, best_d;
  logic [BW-1:0] mode_q, mode_d;
  logic [TW-1:0] run_q, run_d;
  logic [TW-1:0] run_sum;
  logic          found_q, found_d;
  logic [BW-1:0] median_q, median_d;
  logic [TW-1:0] prod;

  // divider
  logic [WW-1:0]  rem_q, rem_d;
  logic [WW-1:0]  dvs_q, dvs_d;
  logic [BW-1:0]  quo_q, quo_d;
  logic [DCW-1:0] divc_q, divc_d;
  logic           div_ge;

  // result register
  logic                           out_valid_q;
  logic [BW-1:0]                  mean_out_q;
  logic [BW-1:0]                  mode_out_q;
  logic [BW-1:0]                  median_out_q;
  logic [TW-1:0]                  total_out_q;
  logic                           empty_out_q;

  assign ram_re    = cmd_i.rec_rd || (cmd_i.walk_run && issuing_q);
  assign ram_raddr = cmd_i.rec_rd ? sample_i[BW-1:0] : walk_addr_q;
  assign cnt       = vld_rd_q ? ram_rdata : '0;
  assign wdata     = cnt + CW'(1);

  hse_ram #(
    .WIDTH (CW),
    .DEPTH (NB)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rec_wr),
    .waddr_i (sample_q),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.clr) begin
      valid_d = '0;
    end else if (cmd_i.rec_wr) begin
      valid_d[sample_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      vld_rd_q <= valid_q[ram_raddr];
    end
    if (cmd_i.rec_rd) begin
      sample_q <= sample_i[BW-1:0];
    end
  end

  always_comb begin
    walk_addr_d = walk_addr_q;
    issuing_d   = issuing_q;
    pend_d      = pend_q;
    rd_idx_d    = rd_idx_q;
    if (cmd_i.walk_init) begin
      walk_addr_d = '0;
      issuing_d   = 1'b1;
      pend_d      = 1'b0;
    end else if (cmd_i.walk_run) begin
      pend_d = issuing_q;
      if (issuing_q) begin
        rd_idx_d    = walk_addr_q;
        walk_addr_d = walk_addr_q + BW'(1);
        if (walk_addr_q == BW'(NB - 1)) begin
          issuing_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_addr_q <= '0;
      issuing_q   <= 1'b0;
      pend_q      <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      walk_addr_q <= walk_addr_d;
      issuing_q   <= issuing_d;
      pend_q      <= pend_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  assign prod    = TW'(cnt) * TW'(rd_idx_q);
  assign run_sum = run_q + TW'(cnt);

  always_comb begin
    total_d  = total_q;
    wsum_d   = wsum_q;
    best_d   = best_q;
    mode_d   = mode_q;
    run_d    = run_q;
    found_d  = found_q;
    median_d = median_q;
    if (cmd_i.init_sum) begin
      total_d = '0;
      wsum_d  = '0;
      best_d  = '0;
      mode_d  = '0;
    end else if (cmd_i.acc_sum && pend_q) begin
      total_d = total_q + TW'(cnt);
      wsum_d  = wsum_q + WW'(prod);
      if (cnt > best_q) begin
        best_d = cnt;
        mode_d = rd_idx_q;
      end
    end
    if (cmd_i.init_med) begin
      run_d    = '0;
      found_d  = 1'b0;
      median_d = '0;
    end else if (cmd_i.acc_med && pend_q) begin
      run_d = run_sum;
      if (!found_q && (run_sum >= (total_q >> 1))) begin
        found_d  = 1'b1;
        median_d = rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q  <= total_d;
    wsum_q   <= wsum_d;
    best_q   <= best_d;
    mode_q   <= mode_d;
    run_q    <= run_d;
    median_q <= median_d;
  end

  // restoring division, one quotient bit per step
  assign div_ge = rem_q >= dvs_q;

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    divc_d = divc_q;
    if (cmd_i.div_init) begin
      rem_d  = wsum_q;
      dvs_d  = WW'(total_q) << (BW - 1);
      quo_d  = '0;
      divc_d = DCW'(BW);
    end else if (cmd_i.div_step) begin
      rem_d  = div_ge ? (rem_q - dvs_q) : rem_q;
      dvs_d  = dvs_q >> 1;
      quo_d  = BW'({quo_q, div_ge});
      divc_d = divc_q - DCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divc_q <= '0;
    end else begin
      divc_q <= divc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mean_out_q   <= (total_q == '0) ? '0 : quo_q;
      mode_out_q   <= mode_q;
      median_out_q <= median_q;
      total_out_q  <= total_q;
      empty_out_q  <= (total_q == '0);
    end
  end

  assign sts_o.walk_last = pend_q && (rd_idx_q == BW'(NB - 1));
  assign sts_o.div_last  = (divc_q == DCW'(1));
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign mean_bin_o    = hse_pkg::BIN_OUT_W'(mean_out_q);
  assign mode_bin_o    = hse_pkg::BIN_OUT_W'(mode_out_q);
  assign median_bin_o  = hse_pkg::BIN_OUT_W'(median_out_q);
  assign total_count_o = hse_pkg::TOTAL_OUT_W'(total_out_q);
  assign empty_res_o   = empty_out_q;

  `HSE_ASSERT(a_rec_sets_valid, cmd_i.rec_wr |=> valid_q[$past(sample_q)], "bin not marked written")
  `HSE_ASSERT(a_run_le_total, cmd_i.acc_med |-> run_q <= total_q, "running sum above total")
  `HSE_ASSERT(a_median_found, cmd_i.div_step |-> found_q, "median pass ended without a hit")
  `HSE_ASSERT(a_mean_range, cmd_i.out_load && total_q != '0 |-> quo_q < BW'(NB), "mean out of range")

endmodule

`default_nettype wire

### design/hse_ctrl.sv
// Controller: request decode and sequencing of record, clear and report
`default_nettype none

`include "histogram_stats_engine_core_assert.svh"

module hse_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           req_valid_i,
  output logic                                req_ready_o,
  input  wire logic [hse_pkg::ACTION_W-1:0]   action_i,
  input  wire logic [hse_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire hse_pkg::sts_t                  sts_i,
  output hse_pkg::cmd_t                       cmd_o
);

  hse_pkg::state_e state_q, state_d;
  logic            in_range;

  assign in_range = 32'(sample_i) < hse_pkg::NUM_BINS;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hse_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          unique case (hse_pkg::action_e'(action_i))
            hse_pkg::ACT_RECORD: begin
              if (in_range) begin
                state_d = hse_pkg::ST_REC_WR;
              end
            end
            hse_pkg::ACT_REPORT: state_d = hse_pkg::ST_SUM;
            default:             state_d = hse_pkg::ST_IDLE;
          endcase
        end
      end
      hse_pkg::ST_REC_WR: state_d = hse_pkg::ST_IDLE;
      hse_pkg::ST_SUM: begin
        if (sts_i.walk_last) begin
          state_d = hse_pkg::ST_MED;
        end
      end
      hse_pkg::ST_MED: begin
        if (sts_i.walk_last) begin
          state_d = hse_pkg::ST_DIV;
        end
      end
      hse_pkg::ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = hse_pkg::ST_RESP;
        end
      end
      hse_pkg::ST_RESP: begin
        if (!sts_i.out_busy) begin
          state_d = hse_pkg::ST_IDLE;
        end
      end
      default: state_d = hse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      hse_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          unique case (hse_pkg::action_e'(action_i))
            hse_pkg::ACT_RECORD: cmd_o.rec_rd = in_range;
            hse_pkg::ACT_CLEAR:  cmd_o.clr    = 1'b1;
            hse_pkg::ACT_REPORT: begin
              cmd_o.walk_init = 1'b1;
              cmd_o.init_sum  = 1'b1;
            end
            default: cmd_o = '0;
          endcase
        end
      end
      hse_pkg::ST_REC_WR: cmd_o.rec_wr = 1'b1;
      hse_pkg::ST_SUM: begin
        cmd_o.walk_run = 1'b1;
        cmd_o.acc_sum  = 1'b1;
        if (sts_i.walk_last) begin
          cmd_o.walk_init = 1'b1;
          cmd_o.init_med  = 1'b1;
        end
      end
      hse_pkg::ST_MED: begin
        cmd_o.walk_run = 1'b1;
        cmd_o.acc_med  = 1'b1;
        cmd_o.div_init = sts_i.walk_last;
      end
      hse_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      hse_pkg::ST_RESP: cmd_o.out_load = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `HSE_ASSERT(a_rec_pair, cmd_o.rec_wr |-> $past(cmd_o.rec_rd), "write without preceding read")
  `HSE_ASSERT(a_walk_state, sts_i.walk_last |-> state_q == hse_pkg::ST_SUM || state_q == hse_pkg::ST_MED, "walk data outside a walk")

endmodule

`default_nettype wire

### design/histogram_stats_engine_core.sv
// Top level of the histogram statistics engine
//
//  channel | dir | handshake         | payload
//  req_i   | in  | valid / ready     | action, sample
//  rsp_o   | out | valid / ready     | mean_bin, mode_bin, median_bin, total_count, empty_res
//
// Record: read of the bin, then write of the incremented count.
// Clear: the per-bin written flags drop at once.
// Report: two walks over the single RAM read port,
//   then one quotient bit per cycle for the mean.
// Reset: all bins read as zero straight after reset; no sweep of the RAM.
// Stalls: the result register holds a finished report while new requests are taken;
//   a further report waits in its last step until that register is free.
`default_nettype none

module histogram_stats_engine_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hse_req_if.sink   req_i,
  hse_rsp_if.source rsp_o
);

  hse_pkg::cmd_t cmd;
  hse_pkg::sts_t sts;

  hse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .action_i    (req_i.action),
    .sample_i    (req_i.sample),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hse_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_i      (req_i.sample),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .mean_bin_o    (rsp_o.mean_bin),
    .mode_bin_o    (rsp_o.mode_bin),
    .median_bin_o  (rsp_o.median_bin),
    .total_count_o (rsp_o.total_count),
    .empty_res_o   (rsp_o.empty_res)
  );

endmodule

`default_nettype wire
